FILE: src/nearest_hit_ray_caster_top_macros.svh
// assertion macros used by the checker
`ifndef NEAREST_HIT_RAY_CASTER_TOP_MACROS_SVH
`define NEAREST_HIT_RAY_CASTER_TOP_MACROS_SVH

// same-cycle implication, ignored while in reset
`define NHRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while in reset
`define NHRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define NHRC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/nhrc_pkg.sv
`default_nettype none
package nhrc_pkg;

  localparam int MAX_SURFACES = 8;
  localparam int FRAC_BITS    = 24;
  localparam int SLOT_W       = $clog2(MAX_SURFACES);
  localparam int CNT_W        = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // hit threshold, 1e-5 in fixed point
  localparam longint EPS_Q = ((64'sd1 <<< FRAC_BITS) + 50000) / 100000;

  // square root radicand width (even) and divider quotient width
  localparam int RW = 2 * ((32 + FRAC_BITS + 1) / 2);
  localparam int QW = 32 + FRAC_BITS;
  localparam int DCNT_W = $clog2(QW + 1);

  // surface kinds
  localparam logic SK_SPHERE = 1'b0;
  localparam logic SK_PLANE  = 1'b1;

  // plane axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic {IT_LOAD, IT_RAY} item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [2:0]         slot;
    logic               skind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] size;
    logic [1:0]         axis;
  } item_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_FETCH, BS_MUL, BS_ACC, BS_SQRT, BS_ROOT, BS_DIV, BS_PICK
  } bk_state_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/nhrc_front.sv
`default_nettype none
module nhrc_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       in_op,
  input  wire logic [2:0]                 in_slot,
  input  wire logic                       in_kind,
  input  wire logic signed [31:0]         in_pos_x,
  input  wire logic signed [31:0]         in_pos_y,
  input  wire logic signed [31:0]         in_pos_z,
  input  wire logic signed [31:0]         in_dir_x,
  input  wire logic signed [31:0]         in_dir_y,
  input  wire logic signed [31:0]         in_dir_z,
  input  wire logic signed [31:0]         in_size_value,
  input  wire logic [1:0]                 in_plane_axis_in,
  input  wire logic                       cfg_we,
  input  wire logic [3:0]                 cfg_wdata,
  input  wire logic                       q_full,
  output logic                            busy,
  output logic                            push,
  output nhrc_pkg::item_t                 item,
  output logic [nhrc_pkg::CNT_W-1:0]      count_n
);

  logic [nhrc_pkg::CNT_W-1:0] cnt_r;

  // surface count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_we) begin
      cnt_r <= cfg_wdata;
    end
  end

  // clamp to table size
  assign count_n = (cnt_r > nhrc_pkg::CNT_W'(nhrc_pkg::MAX_SURFACES)) ?
                   nhrc_pkg::CNT_W'(nhrc_pkg::MAX_SURFACES) : cnt_r;

  // accept while the queue has room
  assign busy = q_full;
  assign push = start && !q_full;

  // classify the transfer and pack it
  always_comb begin
    item.kind  = in_op ? nhrc_pkg::IT_RAY : nhrc_pkg::IT_LOAD;
    item.slot  = in_slot;
    item.skind = in_kind;
    item.px    = in_pos_x;
    item.py    = in_pos_y;
    item.pz    = in_pos_z;
    item.dx    = in_dir_x;
    item.dy    = in_dir_y;
    item.dz    = in_dir_z;
    item.size  = in_size_value;
    item.axis  = in_plane_axis_in;
  end

endmodule
`default_nettype wire

FILE: src/nhrc_queue.sv
`default_nettype none
module nhrc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  nhrc_pkg::item_t      wr_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 valid,
  output nhrc_pkg::item_t      rd_item
);

  nhrc_pkg::item_t                 ent_r [nhrc_pkg::QUEUE_DEPTH];
  logic [nhrc_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [nhrc_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [nhrc_pkg::QCNT_W-1:0]     cnt_r;
  logic                            do_pop;

  assign full    = (cnt_r == nhrc_pkg::QCNT_W'(nhrc_pkg::QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_item = ent_r[rd_ptr_r];
  assign do_pop  = pop && valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wr_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: src/nhrc_back.sv
`default_nettype none
module nhrc_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  nhrc_pkg::item_t                 q_item,
  input  wire logic [nhrc_pkg::CNT_W-1:0] count_n,
  output logic                            pop,
  output logic                            out_strobe,
  output logic                            out_hit,
  output logic [2:0]                      out_hit_slot,
  output logic signed [31:0]              out_hit_distance
);

  localparam int F = nhrc_pkg::FRAC_BITS;
  localparam logic signed [31:0] EPS_T = 32'(nhrc_pkg::EPS_Q);

  // multiply sequence steps
  localparam logic [3:0] MS_DD0 = 4'd0;
  localparam logic [3:0] MS_DD2 = 4'd2;
  localparam logic [3:0] MS_SD0 = 4'd3;
  localparam logic [3:0] MS_SD1 = 4'd4;
  localparam logic [3:0] MS_SD2 = 4'd5;
  localparam logic [3:0] MS_SS0 = 4'd6;
  localparam logic [3:0] MS_SS1 = 4'd7;
  localparam logic [3:0] MS_SS2 = 4'd8;
  localparam logic [3:0] MS_RR  = 4'd9;
  localparam logic [3:0] MS_BB  = 4'd10;
  localparam logic [3:0] MS_AC  = 4'd11;
  localparam logic [3:0] MS_DD1 = 4'd1;

  // surface table
  logic               tbl_kind_r [nhrc_pkg::MAX_SURFACES];
  logic signed [31:0] tbl_cx_r   [nhrc_pkg::MAX_SURFACES];
  logic signed [31:0] tbl_cy_r   [nhrc_pkg::MAX_SURFACES];
  logic signed [31:0] tbl_cz_r   [nhrc_pkg::MAX_SURFACES];
  logic signed [31:0] tbl_size_r [nhrc_pkg::MAX_SURFACES];
  logic [1:0]         tbl_axis_r [nhrc_pkg::MAX_SURFACES];

  nhrc_pkg::bk_state_t state_r, state_nxt;

  logic signed [31:0] ox_r, oy_r, oz_r, dx_r, dy_r, dz_r;
  logic signed [31:0] sx_r, sy_r, sz_r;
  logic signed [31:0] a_r, b_r, ss_r, c_r, bb_r, den_r;
  logic [nhrc_pkg::CNT_W-1:0] k_r, n_r;
  logic [3:0]         mstep_r;
  logic signed [63:0] prod_r;
  logic signed [41:0] acc_r;
  logic [nhrc_pkg::RW-1:0] rad_r, res_r, bit_r;
  logic [nhrc_pkg::QW-1:0] dq_r;
  logic [32:0]        rem_r;
  logic [31:0]        dvs_r;
  logic               neg_r;
  logic [nhrc_pkg::DCNT_W-1:0] dcnt_r;
  logic               found_r;
  logic signed [31:0] best_t_r;
  logic [2:0]         best_slot_r;
  logic               out_strobe_r, out_hit_r;
  logic [2:0]         out_slot_r;
  logic signed [31:0] out_dist_r;

  // current table entry
  logic [nhrc_pkg::SLOT_W-1:0] kidx;
  logic               e_kind;
  logic signed [31:0] e_cx, e_cy, e_cz, e_size;
  logic [1:0]         e_axis;

  logic signed [31:0] opa, opb;
  logic signed [63:0] fq;
  logic signed [41:0] f42, sum;
  logic signed [31:0] sat_sum, sat_f, sat4, dd_v, den_v;
  logic signed [31:0] p_dir, p_org, p_num;
  logic signed [31:0] r_num;
  logic signed [31:0] dv_num, dv_den;
  logic [31:0]        num_mag, den_mag;
  logic [nhrc_pkg::RW-1:0] rb;
  logic [32:0]        remsh;
  logic               ge;
  logic signed [63:0] tv;
  logic signed [31:0] t_v;
  logic               better;
  logic               slot_ok;

  assign kidx   = k_r[nhrc_pkg::SLOT_W-1:0];
  assign e_kind = tbl_kind_r[kidx];
  assign e_cx   = tbl_cx_r[kidx];
  assign e_cy   = tbl_cy_r[kidx];
  assign e_cz   = tbl_cz_r[kidx];
  assign e_size = tbl_size_r[kidx];
  assign e_axis = tbl_axis_r[kidx];

  // multiplier operand select
  always_comb begin
    case (mstep_r)
      MS_DD0:  begin opa = dx_r;   opb = dx_r;   end
      MS_DD1:  begin opa = dy_r;   opb = dy_r;   end
      MS_DD2:  begin opa = dz_r;   opb = dz_r;   end
      MS_SD0:  begin opa = sx_r;   opb = dx_r;   end
      MS_SD1:  begin opa = sy_r;   opb = dy_r;   end
      MS_SD2:  begin opa = sz_r;   opb = dz_r;   end
      MS_SS0:  begin opa = sx_r;   opb = sx_r;   end
      MS_SS1:  begin opa = sy_r;   opb = sy_r;   end
      MS_SS2:  begin opa = sz_r;   opb = sz_r;   end
      MS_RR:   begin opa = e_size; opb = e_size; end
      MS_BB:   begin opa = b_r;    opb = b_r;    end
      MS_AC:   begin opa = a_r;    opb = c_r;    end
      default: begin opa = '0;     opb = '0;     end
    endcase
  end

  // floor-scaled product and dot-product accumulation
  assign fq    = prod_r >>> F;
  assign f42   = 42'(fq);
  assign sum   = (mstep_r == MS_DD0 || mstep_r == MS_SD0 || mstep_r == MS_SS0) ?
                 f42 : acc_r + f42;
  assign sat_sum = nhrc_pkg::sat_q(64'(sum));
  assign sat_f   = nhrc_pkg::sat_q(fq);
  assign sat4    = nhrc_pkg::sat_q(64'(sat_f) <<< 2);
  assign dd_v    = nhrc_pkg::sat_q(64'(bb_r) - 64'(sat4));
  assign den_v   = nhrc_pkg::sat_q(64'(a_r) <<< 1);

  // plane setup
  always_comb begin
    case (e_axis)
      nhrc_pkg::AX_X: begin p_dir = dx_r; p_org = ox_r; end
      nhrc_pkg::AX_Y: begin p_dir = dy_r; p_org = oy_r; end
      nhrc_pkg::AX_Z: begin p_dir = dz_r; p_org = oz_r; end
      default:        begin p_dir = '0;   p_org = '0;   end
    endcase
  end
  assign p_num = nhrc_pkg::sat_q(64'(e_size) - 64'(p_org));

  // sphere root: far root when the origin lies inside
  assign r_num = (64'(c_r) < -nhrc_pkg::EPS_Q) ?
                 nhrc_pkg::sat_q(-64'(b_r) + $signed(64'(res_r))) :
                 nhrc_pkg::sat_q(-64'(b_r) - $signed(64'(res_r)));

  // divider operands and magnitudes
  assign dv_num  = (state_r == nhrc_pkg::BS_ROOT) ? r_num : p_num;
  assign dv_den  = (state_r == nhrc_pkg::BS_ROOT) ? den_r : p_dir;
  assign num_mag = dv_num[31] ? 32'(-dv_num) : 32'(dv_num);
  assign den_mag = dv_den[31] ? 32'(-dv_den) : 32'(dv_den);

  // one square root step
  assign rb = res_r + bit_r;

  // one restoring division step
  assign remsh = {rem_r[31:0], dq_r[nhrc_pkg::QW-1]};
  assign ge    = (remsh >= {1'b0, dvs_r});

  // signed truncated quotient and nearest-hit compare
  assign tv     = neg_r ? -$signed(64'(dq_r)) : $signed(64'(dq_r));
  assign t_v    = nhrc_pkg::sat_q(tv);
  assign better = (t_v > EPS_T) && (!found_r || t_v < best_t_r);

  assign slot_ok = ({1'b0, q_item.slot} < 4'(nhrc_pkg::MAX_SURFACES));

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nhrc_pkg::BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      nhrc_pkg::BS_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_item.kind == nhrc_pkg::IT_RAY) state_nxt = nhrc_pkg::BS_FETCH;
        end
      end
      nhrc_pkg::BS_FETCH: begin
        if (k_r == n_r) state_nxt = nhrc_pkg::BS_IDLE;
        else if (e_kind == nhrc_pkg::SK_SPHERE) state_nxt = nhrc_pkg::BS_MUL;
        else if (p_dir != '0) state_nxt = nhrc_pkg::BS_DIV;
      end
      nhrc_pkg::BS_MUL: state_nxt = nhrc_pkg::BS_ACC;
      nhrc_pkg::BS_ACC: begin
        if (mstep_r == MS_AC) begin
          if (dd_v <= 0 || den_v <= 0) state_nxt = nhrc_pkg::BS_FETCH;
          else state_nxt = nhrc_pkg::BS_SQRT;
        end else begin
          state_nxt = nhrc_pkg::BS_MUL;
        end
      end
      nhrc_pkg::BS_SQRT: if (bit_r == '0) state_nxt = nhrc_pkg::BS_ROOT;
      nhrc_pkg::BS_ROOT: state_nxt = nhrc_pkg::BS_DIV;
      nhrc_pkg::BS_DIV:  if (dcnt_r == '0) state_nxt = nhrc_pkg::BS_PICK;
      nhrc_pkg::BS_PICK: state_nxt = nhrc_pkg::BS_FETCH;
      default: state_nxt = nhrc_pkg::BS_IDLE;
    endcase
  end

  // table writes from load transfers
  always_ff @(posedge clk) begin
    if (state_r == nhrc_pkg::BS_IDLE && q_valid && q_item.kind == nhrc_pkg::IT_LOAD
        && slot_ok) begin
      tbl_kind_r[q_item.slot[nhrc_pkg::SLOT_W-1:0]] <= q_item.skind;
      tbl_cx_r[q_item.slot[nhrc_pkg::SLOT_W-1:0]]   <= q_item.px;
      tbl_cy_r[q_item.slot[nhrc_pkg::SLOT_W-1:0]]   <= q_item.py;
      tbl_cz_r[q_item.slot[nhrc_pkg::SLOT_W-1:0]]   <= q_item.pz;
      tbl_size_r[q_item.slot[nhrc_pkg::SLOT_W-1:0]] <= q_item.size;
      tbl_axis_r[q_item.slot[nhrc_pkg::SLOT_W-1:0]] <= q_item.axis;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      nhrc_pkg::BS_IDLE: begin
        ox_r <= q_item.px; oy_r <= q_item.py; oz_r <= q_item.pz;
        dx_r <= q_item.dx; dy_r <= q_item.dy; dz_r <= q_item.dz;
        k_r  <= '0;
        n_r  <= count_n;
      end
      nhrc_pkg::BS_FETCH: begin
        sx_r    <= nhrc_pkg::sat_q(64'(e_cx) - 64'(ox_r));
        sy_r    <= nhrc_pkg::sat_q(64'(e_cy) - 64'(oy_r));
        sz_r    <= nhrc_pkg::sat_q(64'(e_cz) - 64'(oz_r));
        mstep_r <= MS_DD0;
        if (k_r != n_r && e_kind == nhrc_pkg::SK_PLANE && p_dir == '0) k_r <= k_r + 1'b1;
        dq_r   <= nhrc_pkg::QW'(num_mag) << F;
        dvs_r  <= den_mag;
        neg_r  <= dv_num[31] ^ dv_den[31];
        rem_r  <= '0;
        dcnt_r <= nhrc_pkg::DCNT_W'(nhrc_pkg::QW);
      end
      nhrc_pkg::BS_MUL: prod_r <= 64'(opa) * 64'(opb);
      nhrc_pkg::BS_ACC: begin
        acc_r   <= sum;
        mstep_r <= mstep_r + 1'b1;
        if (mstep_r == MS_DD2) a_r <= sat_sum;
        if (mstep_r == MS_SD2) b_r <= nhrc_pkg::sat_q(-(64'(sat_sum) <<< 1));
        if (mstep_r == MS_SS2) ss_r <= sat_sum;
        if (mstep_r == MS_RR) c_r <= nhrc_pkg::sat_q(64'(ss_r) - 64'(sat_f));
        if (mstep_r == MS_BB) bb_r <= sat_f;
        if (mstep_r == MS_AC) begin
          den_r <= den_v;
          rad_r <= nhrc_pkg::RW'($unsigned(dd_v)) << F;
          res_r <= '0;
          bit_r <= nhrc_pkg::RW'(1) << (nhrc_pkg::RW - 2);
          if (dd_v <= 0 || den_v <= 0) k_r <= k_r + 1'b1;
        end
      end
      nhrc_pkg::BS_SQRT: begin
        if (bit_r != '0) begin
          if (rad_r >= rb) begin
            rad_r <= rad_r - rb;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
      end
      nhrc_pkg::BS_ROOT: begin
        dq_r   <= nhrc_pkg::QW'(num_mag) << F;
        dvs_r  <= den_mag;
        neg_r  <= dv_num[31] ^ dv_den[31];
        rem_r  <= '0;
        dcnt_r <= nhrc_pkg::DCNT_W'(nhrc_pkg::QW);
      end
      nhrc_pkg::BS_DIV: begin
        if (dcnt_r != '0) begin
          rem_r  <= ge ? remsh - {1'b0, dvs_r} : remsh;
          dq_r   <= {dq_r[nhrc_pkg::QW-2:0], ge};
          dcnt_r <= dcnt_r - 1'b1;
        end
      end
      nhrc_pkg::BS_PICK: begin
        k_r <= k_r + 1'b1;
        if (better) begin
          best_t_r    <= t_v;
          best_slot_r <= k_r[2:0];
        end
      end
      default: ;
    endcase
  end

  // hit flag and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (state_r == nhrc_pkg::BS_IDLE) found_r <= 1'b0;
      else if (state_r == nhrc_pkg::BS_PICK && better) found_r <= 1'b1;
      if (state_r == nhrc_pkg::BS_FETCH && k_r == n_r) out_strobe_r <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == nhrc_pkg::BS_FETCH && k_r == n_r) begin
      out_hit_r  <= found_r;
      out_slot_r <= found_r ? best_slot_r : 3'd0;
      out_dist_r <= found_r ? best_t_r : 32'sd0;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_hit          = out_hit_r;
  assign out_hit_slot     = out_slot_r;
  assign out_hit_distance = out_dist_r;

endmodule
`default_nettype wire

FILE: src/nearest_hit_ray_caster_top.sv
// load transfer: held in the queue, then written to the table when the engine is idle, no result
// ray: out_strobe rises once every slot below surface_count is tried; a sphere slot runs the bit-serial
//   square root (28 steps) and divider (56 steps) unless ruled out; planes use the divider unless parallel
// a two-entry queue takes new transfers while a ray is worked on; busy = queue full
// results cannot be stalled; out_strobe is high for exactly one cycle per ray
// synchronous active-low reset empties the queue and clears surface_count; table is undefined
`default_nettype none
module nearest_hit_ray_caster_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_op,
  input  wire logic [2:0]         in_slot,
  input  wire logic               in_kind,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_dir_x,
  input  wire logic signed [31:0] in_dir_y,
  input  wire logic signed [31:0] in_dir_z,
  input  wire logic signed [31:0] in_size_value,
  input  wire logic [1:0]         in_plane_axis_in,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic [2:0]              out_hit_slot,
  output logic signed [31:0]      out_hit_distance
);

  logic                              q_full, q_valid, push, pop;
  nhrc_pkg::item_t                   wr_item, rd_item;
  logic [nhrc_pkg::CNT_W-1:0]        count_n;

  // accept and classify
  nhrc_front u_front (
    .clk, .rst_n, .start,
    .in_op, .in_slot, .in_kind,
    .in_pos_x, .in_pos_y, .in_pos_z,
    .in_dir_x, .in_dir_y, .in_dir_z,
    .in_size_value, .in_plane_axis_in,
    .cfg_we, .cfg_wdata,
    .q_full, .busy, .push,
    .item(wr_item), .count_n
  );

  // decoupling queue
  nhrc_queue u_queue (
    .clk, .rst_n, .push, .wr_item,
    .pop, .full(q_full), .valid(q_valid), .rd_item
  );

  // table and intersection engine
  nhrc_back u_back (
    .clk, .rst_n, .q_valid, .q_item(rd_item), .count_n, .pop,
    .out_strobe, .out_hit, .out_hit_slot, .out_hit_distance
  );

endmodule
`default_nettype wire

FILE: src/nhrc_checker.sv
`default_nettype none
`include "nearest_hit_ray_caster_top_macros.svh"
module nhrc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire logic               out_hit,
  input wire logic [2:0]         out_hit_slot,
  input wire logic signed [31:0] out_hit_distance
);

  // a miss reports zero slot and zero distance
  `NHRC_ASSERT_NOW(a_miss_zero, out_strobe && !out_hit, out_hit_slot == 3'd0 && out_hit_distance == 32'sd0, "miss result not zeroed")

  // a hit lies beyond the threshold, so its distance is positive
  `NHRC_ASSERT_NOW(a_hit_pos, out_strobe && out_hit, out_hit_distance > 32'sd0, "hit distance not positive")

  // no two results come back to back
  `NHRC_ASSERT_NEXT(a_strobe_gap, out_strobe, !out_strobe, "back to back results")

  // reset leaves no result and busy low, as the queue is empty
  `NHRC_ASSERT_RST(a_reset_quiet, !rst_n, !out_strobe && !busy, "activity after reset")

endmodule

bind nearest_hit_ray_caster_top nhrc_checker u_nhrc_checker (.*);
`default_nettype wire
